### design/vfx_pkg.sv
`timescale 1ns / 1ps
// vfx_pkg: widths, types and mode codes for the vector frame transform
// no dependencies; imported by every module of the block
package vfx_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int UBITS      = 30;
    localparam int U_W        = UBITS + 2;
    localparam int CR_W       = (DATA_WIDTH > U_W) ? DATA_WIDTH : U_W;
    localparam int MAG_W      = 2 * CR_W;
    localparam int LEAD_W     = $clog2(MAG_W);
    localparam int SUM_W      = 2 * UBITS + 2;
    localparam int NUM_W      = 2 * UBITS + 1;
    localparam int Q_W        = UBITS + 1;
    localparam int SQ_STEPS   = Q_W;
    localparam int DIV_STEPS  = Q_W;
    localparam int NORM_LAT   = 6 + SQ_STEPS + DIV_STEPS;
    localparam int VEC_W      = 9 * DATA_WIDTH;
    localparam int TDATA_W    = ((VEC_W + 7) / 8) * 8;

    localparam logic [1:0] FUNC_FWD = 2'd0;
    localparam logic [1:0] FUNC_INV = 2'd1;
    localparam logic [1:0] FUNC_CLR = 2'd2;

    typedef logic [2:0][MAG_W-1:0]      mag3_t;
    typedef logic [2:0][U_W-1:0]        unit3_t;
    typedef logic [2:0][CR_W-1:0]       cvec_t;
    typedef logic [8:0][DATA_WIDTH-1:0] vec9_t;

    typedef struct packed {
        logic [1:0] func;
        vec9_t      v;
    } item_t;

    typedef struct packed {
        item_t  item;
        unit3_t ux;
        unit3_t uz;
        logic   bad;
    } mid_t;

endpackage

### design/vfx_cross.sv
`timescale 1ns / 1ps
// vfx_cross: two-stage exact cross product p x q as sign and magnitude
// depends on vfx_pkg
module vfx_cross (
    input  logic           aclk,
    input  logic           en,
    input  vfx_pkg::cvec_t p,
    input  vfx_pkg::cvec_t q,
    output logic [2:0]     sg,
    output vfx_pkg::mag3_t mg
);
    import vfx_pkg::*;

    logic [2:0][1:0][2*CR_W-1:0] pr;
    logic [2:0][1:0][2*CR_W-1:0] pr_reg;
    logic [2:0]                  sg_reg;
    mag3_t                       mg_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pr[k][0] = $signed(p[(k == 2) ? 0 : k + 1]) * $signed(q[(k == 0) ? 2 : k - 1]);
            pr[k][1] = $signed(p[(k == 0) ? 2 : k - 1]) * $signed(q[(k == 2) ? 0 : k + 1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg <= pr;
            for (int k = 0; k < 3; k++) begin
                sg_reg[k] <= $signed(pr_reg[k][0]) < $signed(pr_reg[k][1]);
                if ($signed(pr_reg[k][0]) < $signed(pr_reg[k][1])) begin
                    mg_reg[k] <= MAG_W'(pr_reg[k][1] - pr_reg[k][0]);
                end else begin
                    mg_reg[k] <= MAG_W'(pr_reg[k][0] - pr_reg[k][1]);
                end
            end
        end
    end

    assign sg = sg_reg;
    assign mg = mg_reg;

endmodule

### design/vfx_norm.sv
`timescale 1ns / 1ps
// vfx_norm: pipelined normalisation of a sign/magnitude 3-vector to Q2.30
// lead search, shift, squares, bit-per-stage square root and division; uses vfx_pkg
module vfx_norm (
    input  logic            aclk,
    input  logic            en,
    input  logic [2:0]      sg_in,
    input  vfx_pkg::mag3_t  mg_in,
    output vfx_pkg::unit3_t u_out,
    output logic            zero_out
);
    import vfx_pkg::*;

    typedef struct packed {
        logic [2:0]            sg;
        logic                  zero;
        logic [2:0][UBITS-1:0] mg;
    } side_t;

    // leading one of the widest component
    logic [MAG_W-1:0]  or_w;
    logic [LEAD_W-1:0] lead;
    logic [LEAD_W-1:0] a_lead_reg;
    logic              a_zero_reg;
    logic [2:0]        a_sg_reg;
    mag3_t             a_mg_reg;

    assign or_w = mg_in[0] | mg_in[1] | mg_in[2];

    always_comb begin
        lead = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (or_w[i]) begin
                lead = LEAD_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_lead_reg <= lead;
            a_zero_reg <= (or_w == '0);
            a_sg_reg   <= sg_in;
            a_mg_reg   <= mg_in;
        end
    end

    // shift so the top bit lands on bit UBITS-1
    side_t b_next;
    side_t b_side_reg;

    always_comb begin
        b_next.sg   = a_sg_reg;
        b_next.zero = a_zero_reg;
        for (int j = 0; j < 3; j++) begin
            if (a_lead_reg >= LEAD_W'(UBITS - 1)) begin
                b_next.mg[j] = UBITS'(a_mg_reg[j] >> (a_lead_reg - LEAD_W'(UBITS - 1)));
            end else begin
                b_next.mg[j] = UBITS'(a_mg_reg[j] << (LEAD_W'(UBITS - 1) - a_lead_reg));
            end
        end
    end

    logic [2:0][2*UBITS-1:0] c_sq_reg;
    side_t                   c_side_reg;
    logic [SUM_W-1:0]        d_sum_reg;
    side_t                   d_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= b_next;
            for (int j = 0; j < 3; j++) begin
                c_sq_reg[j] <= (2*UBITS)'(b_side_reg.mg[j]) * (2*UBITS)'(b_side_reg.mg[j]);
            end
            c_side_reg <= b_side_reg;
            d_sum_reg  <= SUM_W'(c_sq_reg[0]) + SUM_W'(c_sq_reg[1]) + SUM_W'(c_sq_reg[2]);
            d_side_reg <= c_side_reg;
        end
    end

    // floor square root, one result bit per stage
    logic [SUM_W-1:0] sq_rem_reg  [SQ_STEPS];
    logic [Q_W-1:0]   sq_root_reg [SQ_STEPS];
    side_t            sq_side_reg [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        localparam int B = SQ_STEPS - 1 - k;
        logic [SUM_W-1:0] rem_in;
        logic [Q_W-1:0]   root_in;
        side_t            side_in;
        logic [SUM_W+1:0] trial;

        if (k == 0) begin : g_head
            assign rem_in  = d_sum_reg;
            assign root_in = '0;
            assign side_in = d_side_reg;
        end else begin : g_tail
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        assign trial = ((SUM_W+2)'(root_in) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (en) begin
                if ((SUM_W+2)'(rem_in) >= trial) begin
                    sq_rem_reg[k]  <= rem_in - SUM_W'(trial);
                    sq_root_reg[k] <= root_in | (Q_W'(1) << B);
                end else begin
                    sq_rem_reg[k]  <= rem_in;
                    sq_root_reg[k] <= root_in;
                end
                sq_side_reg[k] <= side_in;
            end
        end
    end

    // numerator with half the divisor for rounding
    logic [2:0][NUM_W-1:0] e_num_reg;
    logic [Q_W-1:0]        e_n_reg;
    side_t                 e_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                e_num_reg[j] <= (NUM_W'(sq_side_reg[SQ_STEPS-1].mg[j]) << UBITS)
                              + NUM_W'(sq_root_reg[SQ_STEPS-1] >> 1);
            end
            e_n_reg    <= sq_root_reg[SQ_STEPS-1];
            e_side_reg <= sq_side_reg[SQ_STEPS-1];
        end
    end

    // restoring division, one quotient bit per stage, three lanes
    logic [2:0][NUM_W-1:0] dv_rem_reg  [DIV_STEPS];
    logic [2:0][Q_W-1:0]   dv_q_reg    [DIV_STEPS];
    logic [Q_W-1:0]        dv_n_reg    [DIV_STEPS];
    side_t                 dv_side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int B = DIV_STEPS - 1 - k;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][Q_W-1:0]   q_in;
        logic [Q_W-1:0]        n_in;
        side_t                 side_in;
        logic [NUM_W:0]        dsh;

        if (k == 0) begin : g_head
            assign rem_in  = e_num_reg;
            assign q_in    = '0;
            assign n_in    = e_n_reg;
            assign side_in = e_side_reg;
        end else begin : g_tail
            assign rem_in  = dv_rem_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign n_in    = dv_n_reg[k-1];
            assign side_in = dv_side_reg[k-1];
        end

        assign dsh = (NUM_W+1)'(n_in) << B;

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    if ((NUM_W+1)'(rem_in[j]) >= dsh) begin
                        dv_rem_reg[k][j] <= rem_in[j] - NUM_W'(dsh);
                        dv_q_reg[k][j]   <= q_in[j] | (Q_W'(1) << B);
                    end else begin
                        dv_rem_reg[k][j] <= rem_in[j];
                        dv_q_reg[k][j]   <= q_in[j];
                    end
                end
                dv_n_reg[k]    <= n_in;
                dv_side_reg[k] <= side_in;
            end
        end
    end

    unit3_t u_reg;
    logic   zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                if (dv_side_reg[DIV_STEPS-1].zero) begin
                    u_reg[j] <= '0;
                end else if (dv_side_reg[DIV_STEPS-1].sg[j]) begin
                    u_reg[j] <= -U_W'(dv_q_reg[DIV_STEPS-1][j]);
                end else begin
                    u_reg[j] <= U_W'(dv_q_reg[DIV_STEPS-1][j]);
                end
            end
            zero_reg <= dv_side_reg[DIV_STEPS-1].zero;
        end
    end

    assign u_out    = u_reg;
    assign zero_out = zero_reg;

endmodule

### design/vfx_mat.sv
`timescale 1ns / 1ps
// vfx_mat: three-stage rotation of the nine inputs by the frame matrix
// products, sums, then rounding, saturation and mode handling; uses vfx_pkg
module vfx_mat (
    input  logic            aclk,
    input  logic            en,
    input  logic [1:0]      func,
    input  logic            bad,
    input  vfx_pkg::vec9_t  v,
    input  vfx_pkg::unit3_t ux,
    input  vfx_pkg::unit3_t uy,
    input  vfx_pkg::unit3_t uz,
    output vfx_pkg::vec9_t  res,
    output logic            degenerate
);
    import vfx_pkg::*;

    localparam int PW = DATA_WIDTH + U_W;
    localparam int SW = PW + 2;
    localparam int RW = SW + 1 - UBITS;
    localparam logic signed [RW-1:0] HI = RW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] LO = -HI - RW'(1);

    unit3_t                 mt [3];
    logic [8:0][2:0][PW-1:0] prod;
    logic [8:0][2:0][PW-1:0] m1_prod_reg;
    logic [1:0]             m1_func_reg;
    logic                   m1_bad_reg;
    logic [8:0][SW-1:0]     m2_sum_reg;
    logic [1:0]             m2_func_reg;
    logic                   m2_bad_reg;
    vec9_t                  res_reg;
    logic                   deg_reg;
    logic signed [SW:0]     t    [9];
    logic signed [RW-1:0]   r    [9];
    vec9_t                  res_next;

    assign mt[0] = ux;
    assign mt[1] = uy;
    assign mt[2] = uz;

    always_comb begin
        for (int w = 0; w < 3; w++) begin
            for (int rr = 0; rr < 3; rr++) begin
                for (int k = 0; k < 3; k++) begin
                    if (func == FUNC_FWD) begin
                        prod[3*w+rr][k] = $signed(v[3*w+k]) * $signed(mt[rr][k]);
                    end else begin
                        prod[3*w+rr][k] = $signed(v[3*w+k]) * $signed(mt[k][rr]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 9; i++) begin
            t[i] = (SW+1)'($signed(m2_sum_reg[i])) + (SW+1)'(64'd1 << (UBITS - 1));
            r[i] = RW'(t[i] >>> UBITS);
            if (r[i] > HI) begin
                res_next[i] = DATA_WIDTH'(HI);
            end else if (r[i] < LO) begin
                res_next[i] = DATA_WIDTH'(LO);
            end else begin
                res_next[i] = DATA_WIDTH'(r[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_prod_reg <= prod;
            m1_func_reg <= func;
            m1_bad_reg  <= bad;
            for (int i = 0; i < 9; i++) begin
                m2_sum_reg[i] <= SW'($signed(m1_prod_reg[i][0])) + SW'($signed(m1_prod_reg[i][1]))
                               + SW'($signed(m1_prod_reg[i][2]));
            end
            m2_func_reg <= m1_func_reg;
            m2_bad_reg  <= m1_bad_reg;
            if (m2_func_reg != FUNC_FWD && m2_func_reg != FUNC_INV) begin
                res_reg <= '0;
                deg_reg <= 1'b0;
            end else if (m2_bad_reg) begin
                res_reg <= '0;
                deg_reg <= 1'b1;
            end else begin
                res_reg <= res_next;
                deg_reg <= 1'b0;
            end
        end
    end

    assign res        = res_reg;
    assign degenerate = deg_reg;

endmodule

### design/vector_frame_transform.sv
`timescale 1ns / 1ps
// vector_frame_transform: streaming rotation of vectors a, b, c into the frame set by a and b
// uses vfx_pkg, vfx_cross, vfx_norm and vfx_mat
//
// s_tdata carries a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (signed Q15.16, lowest first),
// s_tuser the mode: forward, inverse, or clear. m_tdata carries the nine rotated components
// in the same order and m_tuser flags a degenerate frame (a or b zero, or a parallel to b),
// in which case all components are zero; a clear mode gives an all-zero item, flag included.
// One item is taken per cycle while s_tready is high, and every item gives exactly one
// result item. The pipeline depth is set by the two chained normalisers: each has a square
// root and a divider resolving one bit per stage.
// The whole pipeline moves as one: when a result waits at the output register and
// m_tready is low, s_tready drops and every stage holds; nothing is lost or repeated.
// Reset clears all valid bits; s_tready is high straight after reset.
module vector_frame_transform (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [vfx_pkg::TDATA_W-1:0] s_tdata,   // a_x a_y a_z b_x b_y b_z c_x c_y c_z
    input  logic [1:0]                  s_tuser,   // func
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [vfx_pkg::TDATA_W-1:0] m_tdata,   // new_a_x .. new_c_z
    output logic [0:0]                  m_tuser    // degenerate
);
    import vfx_pkg::*;

    localparam int D1 = NORM_LAT + 2;

    logic   adv;
    item_t  p0_item_reg;
    logic   p0_vld_reg;
    item_t  dl1_reg [D1];
    logic   v1_reg  [D1];
    mid_t   dl2_reg [D1];
    logic   v2_reg  [D1];
    logic   vm_reg  [3];
    logic [2:0]      xa_sg_reg [2];
    mag3_t           xa_mg_reg [2];
    logic [2:0]      xa_sg;
    mag3_t           xa_mg;
    cvec_t           pa;
    cvec_t           pb;
    cvec_t           pz;
    cvec_t           px;
    logic [2:0]      z_sg;
    mag3_t           z_mg;
    logic [2:0]      y_sg;
    mag3_t           y_mg;
    unit3_t          uz;
    unit3_t          ux;
    unit3_t          uy;
    logic            uz_zero;
    logic            ux_zero;
    logic            uy_zero;
    mid_t            mid;
    vec9_t           res;
    logic            deg;

    assign adv      = !vm_reg[2] || m_tready;
    assign s_tready = adv;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pa[k]    = CR_W'($signed(p0_item_reg.v[k]));
            pb[k]    = CR_W'($signed(p0_item_reg.v[3+k]));
            xa_sg[k] = p0_item_reg.v[k][DATA_WIDTH-1];
            xa_mg[k] = xa_sg[k]
                     ? MAG_W'(-$signed({p0_item_reg.v[k][DATA_WIDTH-1], p0_item_reg.v[k]}))
                     : MAG_W'($signed({p0_item_reg.v[k][DATA_WIDTH-1], p0_item_reg.v[k]}));
            pz[k]    = CR_W'($signed(uz[k]));
            px[k]    = CR_W'($signed(ux[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_vld_reg <= 1'b0;
            for (int i = 0; i < D1; i++) begin
                v1_reg[i] <= 1'b0;
                v2_reg[i] <= 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                vm_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            p0_vld_reg <= s_tvalid;
            v1_reg[0]  <= p0_vld_reg;
            v2_reg[0]  <= v1_reg[D1-1];
            for (int i = 1; i < D1; i++) begin
                v1_reg[i] <= v1_reg[i-1];
                v2_reg[i] <= v2_reg[i-1];
            end
            vm_reg[0] <= v2_reg[D1-1];
            vm_reg[1] <= vm_reg[0];
            vm_reg[2] <= vm_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p0_item_reg.func <= s_tuser;
            p0_item_reg.v    <= s_tdata[VEC_W-1:0];
            xa_sg_reg[0]     <= xa_sg;
            xa_mg_reg[0]     <= xa_mg;
            xa_sg_reg[1]     <= xa_sg_reg[0];
            xa_mg_reg[1]     <= xa_mg_reg[0];
            dl1_reg[0]       <= p0_item_reg;
            dl2_reg[0]       <= mid;
            for (int i = 1; i < D1; i++) begin
                dl1_reg[i] <= dl1_reg[i-1];
                dl2_reg[i] <= dl2_reg[i-1];
            end
        end
    end

    assign mid.item = dl1_reg[D1-1];
    assign mid.ux   = ux;
    assign mid.uz   = uz;
    assign mid.bad  = uz_zero || ux_zero;

    vfx_cross u_cross_ab (
        .aclk (aclk),
        .en   (adv),
        .p    (pa),
        .q    (pb),
        .sg   (z_sg),
        .mg   (z_mg)
    );

    vfx_norm u_norm_z (
        .aclk     (aclk),
        .en       (adv),
        .sg_in    (z_sg),
        .mg_in    (z_mg),
        .u_out    (uz),
        .zero_out (uz_zero)
    );

    vfx_norm u_norm_x (
        .aclk     (aclk),
        .en       (adv),
        .sg_in    (xa_sg_reg[1]),
        .mg_in    (xa_mg_reg[1]),
        .u_out    (ux),
        .zero_out (ux_zero)
    );

    vfx_cross u_cross_zx (
        .aclk (aclk),
        .en   (adv),
        .p    (pz),
        .q    (px),
        .sg   (y_sg),
        .mg   (y_mg)
    );

    vfx_norm u_norm_y (
        .aclk     (aclk),
        .en       (adv),
        .sg_in    (y_sg),
        .mg_in    (y_mg),
        .u_out    (uy),
        .zero_out (uy_zero)
    );

    vfx_mat u_mat (
        .aclk       (aclk),
        .en         (adv),
        .func       (dl2_reg[D1-1].item.func),
        .bad        (dl2_reg[D1-1].bad || uy_zero),
        .v          (dl2_reg[D1-1].item.v),
        .ux         (dl2_reg[D1-1].ux),
        .uy         (uy),
        .uz         (dl2_reg[D1-1].uz),
        .res        (res),
        .degenerate (deg)
    );

    assign m_tvalid          = vm_reg[2];
    assign m_tdata[VEC_W-1:0] = res;
    assign m_tuser[0]        = deg;

    if (TDATA_W > VEC_W) begin : g_pad
        assign m_tdata[TDATA_W-1:VEC_W] = '0;
    end

endmodule

### design/vfx_check.sv
`timescale 1ns / 1ps
// vfx_check: port-level checks for vector_frame_transform, bound to the top level
// depends on vfx_pkg
module vfx_check (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [vfx_pkg::TDATA_W-1:0] s_tdata,
    input logic [1:0]                  s_tuser,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [vfx_pkg::TDATA_W-1:0] m_tdata,
    input logic [0:0]                  m_tuser
);
    import vfx_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled item changed");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("waiting input item changed");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate item with data");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind vector_frame_transform vfx_check u_vfx_check (.*);
